>>> rtl/wrhp_pkg.sv
// ----------------------------------------------------------------------------
// wrhp_pkg
// Shared types and constants for the WAV RIFF header parser.
// ----------------------------------------------------------------------------
package wrhp_pkg;

	// default width of the saturating byte position counter
	localparam int OFFSET_BITS_DEF = 32;

	// chunk and header tags, first byte in the top octet
	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam int MIN_FILE  = 44;
	localparam int MIN_FMT   = 16;
	localparam int FMT_BYTES = 18;

	// status codes of the result item
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_HDR   = 3'd1;
	localparam logic [2:0] ST_OVERRUN   = 3'd2;
	localparam logic [2:0] ST_FMT_SMALL = 3'd3;
	localparam logic [2:0] ST_MISSING   = 3'd4;
	localparam logic [2:0] ST_NOT_PCM   = 3'd5;
	localparam logic [2:0] ST_NOT_8BIT  = 3'd6;

	// one byte of the file
	typedef struct packed {
		logic [7:0] file_byte;
		logic       end_of_file;
	} in_item_t;

	// one status report per file
	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] format_tag;
		logic [15:0] channel_count;
		logic [31:0] sample_rate;
		logic [31:0] byte_rate;
		logic [15:0] block_align;
		logic [15:0] sample_bits;
		logic [15:0] extra_size;
		logic [31:0] data_offset;
		logic [31:0] data_size;
	} out_item_t;

endpackage

>>> rtl/wrhp_if.sv
// ----------------------------------------------------------------------------
// wrhp_if
// Valid/ready channels of the WAV RIFF header parser: byte in, report out.
// ----------------------------------------------------------------------------
interface wrhp_in_if;
	logic               valid;
	logic               ready;
	wrhp_pkg::in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

interface wrhp_out_if;
	logic                valid;
	logic                ready;
	wrhp_pkg::out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

>>> rtl/wav_riff_header_parser_unit.sv
// ----------------------------------------------------------------------------
// wav_riff_header_parser_unit
// Parses a WAV file byte stream and reports status and fmt/data fields.
// ----------------------------------------------------------------------------
//  channel  | role | item          | accepted when
//  ---------+------+---------------+---------------------------
//  bytes    | sink | file byte+eof | bytes.valid & bytes.ready
//  result   | src  | status report | result.valid & result.ready
//
//  One byte per cycle unless stalled as below: input register, one pass of
//  parse logic, state update. The report of a final byte is registered.
//  A report waits in the result register; bytes keep flowing behind it and
//  only a second end of file stalls until the report is taken.
//  arst_n clears all parse state; after each report the state returns to reset.
// ----------------------------------------------------------------------------
module wav_riff_header_parser_unit #(
	parameter int OFFSET_BITS = wrhp_pkg::OFFSET_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	wrhp_in_if.sink            bytes,
	wrhp_out_if.source         result
);

	// parse phases
	localparam logic [2:0] PH_HEADER    = 3'd0;
	localparam logic [2:0] PH_CHUNK_HDR = 3'd1;
	localparam logic [2:0] PH_BODY      = 3'd2;
	localparam logic [2:0] PH_SMALL_FMT = 3'd3;
	localparam logic [2:0] PH_DONE      = 3'd4;

	localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};
	localparam int NFMT = wrhp_pkg::FMT_BYTES;

	// input register
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;
	logic       adv;

	// parse state
	logic [OFFSET_BITS-1:0] pos_q, pos_d, pos_inc;
	logic [2:0]             phase_q, phase_d;
	logic [31:0]            tag_q, tag_d;
	logic [31:0]            clen_q, clen_d;
	logic [32:0]            left_q, left_d;
	logic                   in_fmt_q, in_fmt_d;
	logic [7:0]             fmt_q [NFMT];
	logic [7:0]             fmt_d [NFMT];
	logic [OFFSET_BITS-1:0] doff_q, doff_d;
	logic [31:0]            dsize_q, dsize_d;
	logic [1:0]             found_q, found_d;
	logic [2:0]             err_q, err_d;

	// result register
	logic                out_vld_q;
	wrhp_pkg::out_item_t out_item_q;
	wrhp_pkg::out_item_t res_d;

	logic        end_req;
	logic [2:0]  k;
	logic [32:0] idx;
	logic [2:0]  st;

	// advance when the byte causes no report or the result slot frees up
	assign adv          = vld_s1 && (!eof_s1 || !out_vld_q || result.ready);
	assign bytes.ready  = !vld_s1 || adv;
	assign result.valid = out_vld_q;
	assign result.item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (bytes.ready) begin
			vld_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1 <= bytes.item.file_byte;
			eof_s1  <= bytes.item.end_of_file;
		end
	end

	// next state and report for the byte in the input register
	always_comb begin
		pos_inc  = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
		pos_d    = pos_q;
		phase_d  = phase_q;
		tag_d    = tag_q;
		clen_d   = clen_q;
		left_d   = left_q;
		in_fmt_d = in_fmt_q;
		fmt_d    = fmt_q;
		doff_d   = doff_q;
		dsize_d  = dsize_q;
		found_d  = found_q;
		err_d    = err_q;
		end_req  = 1'b0;
		k        = left_q[2:0];
		idx      = '0;
		st       = wrhp_pkg::ST_OK;
		res_d    = '0;

		if (adv) begin
			pos_d = pos_inc;
			if (err_q == wrhp_pkg::ST_OK) begin
				case (phase_q)
					PH_HEADER: begin
						tag_d = {tag_q[23:0], byte_s1};
						if (pos_q == OFFSET_BITS'(3) && tag_d != wrhp_pkg::TAG_RIFF) begin
							err_d   = wrhp_pkg::ST_BAD_HDR;
							phase_d = PH_DONE;
						end else if (pos_q >= OFFSET_BITS'(11)) begin
							if (tag_d != wrhp_pkg::TAG_WAVE) begin
								err_d   = wrhp_pkg::ST_BAD_HDR;
								phase_d = PH_DONE;
							end else begin
								phase_d = PH_CHUNK_HDR;
								left_d  = '0;
							end
						end
					end
					PH_CHUNK_HDR: begin
						// tag in bytes 0..3, little-endian size in bytes 4..7
						case (k)
							3'd4: clen_d = {24'd0, byte_s1};
							3'd5: clen_d[15:8] = byte_s1;
							3'd6: clen_d[23:16] = byte_s1;
							3'd7: clen_d[31:24] = byte_s1;
							default: tag_d = {tag_q[23:0], byte_s1};
						endcase
						left_d = 33'(k) + 33'd1;
						if (k == 3'd7) begin
							left_d   = {1'b0, clen_d} + 33'(clen_d[0]);
							in_fmt_d = 1'b0;
							phase_d  = PH_BODY;
							if (tag_q == wrhp_pkg::TAG_FMT) begin
								if (clen_d < 32'(wrhp_pkg::MIN_FMT)) begin
									phase_d = PH_SMALL_FMT;
								end else begin
									in_fmt_d = 1'b1;
									for (int i = 0; i < NFMT; i++) fmt_d[i] = '0;
									found_d[0] = 1'b1;
								end
							end else if (tag_q == wrhp_pkg::TAG_DATA) begin
								doff_d     = pos_inc;
								dsize_d    = clen_d;
								found_d[1] = 1'b1;
							end
							end_req = (clen_d == 32'd0);
						end
					end
					PH_BODY, PH_SMALL_FMT: begin
						if (left_q == 33'd0) begin
							end_req = 1'b1;
						end else begin
							idx = ({1'b0, clen_q} + 33'(clen_q[0])) - left_q;
							if (in_fmt_q && idx < 33'(NFMT) &&
							    (idx < 33'(wrhp_pkg::MIN_FMT) ||
							     clen_q > 32'(wrhp_pkg::MIN_FMT))) begin
								fmt_d[idx[4:0]] = byte_s1;
							end
							left_d  = left_q - 33'd1;
							end_req = (left_d == 33'd0);
						end
					end
					default: begin
					end
				endcase

				// end of chunk body and padding
				if (end_req) begin
					if (phase_d == PH_SMALL_FMT) begin
						err_d   = wrhp_pkg::ST_FMT_SMALL;
						phase_d = PH_DONE;
					end else begin
						phase_d  = PH_CHUNK_HDR;
						left_d   = '0;
						in_fmt_d = 1'b0;
					end
				end
			end

			// report status, in order of precedence
			if (pos_d < OFFSET_BITS'(wrhp_pkg::MIN_FILE) || err_d == wrhp_pkg::ST_BAD_HDR) begin
				st = wrhp_pkg::ST_BAD_HDR;
			end else if (err_d != wrhp_pkg::ST_OK) begin
				st = err_d;
			end else if ((phase_d == PH_BODY || phase_d == PH_SMALL_FMT) &&
			             left_d != 33'd0) begin
				st = wrhp_pkg::ST_OVERRUN;
			end else if (found_d != 2'b11) begin
				st = wrhp_pkg::ST_MISSING;
			end else if ({fmt_d[1], fmt_d[0]} != 16'd1) begin
				st = wrhp_pkg::ST_NOT_PCM;
			end else if ({fmt_d[15], fmt_d[14]} != 16'd8) begin
				st = wrhp_pkg::ST_NOT_8BIT;
			end

			res_d.status = st;
			if (st == wrhp_pkg::ST_OK || st == wrhp_pkg::ST_NOT_PCM ||
			    st == wrhp_pkg::ST_NOT_8BIT) begin
				res_d.format_tag    = {fmt_d[1], fmt_d[0]};
				res_d.channel_count = {fmt_d[3], fmt_d[2]};
				res_d.sample_rate   = {fmt_d[7], fmt_d[6], fmt_d[5], fmt_d[4]};
				res_d.byte_rate     = {fmt_d[11], fmt_d[10], fmt_d[9], fmt_d[8]};
				res_d.block_align   = {fmt_d[13], fmt_d[12]};
				res_d.sample_bits   = {fmt_d[15], fmt_d[14]};
				res_d.extra_size    = {fmt_d[17], fmt_d[16]};
				res_d.data_offset   = 32'(doff_d);
				res_d.data_size     = dsize_d;
			end

			// a new file starts after the final byte
			if (eof_s1) begin
				pos_d    = '0;
				phase_d  = PH_HEADER;
				tag_d    = '0;
				clen_d   = '0;
				left_d   = '0;
				in_fmt_d = 1'b0;
				for (int i = 0; i < NFMT; i++) fmt_d[i] = '0;
				doff_d   = '0;
				dsize_d  = '0;
				found_d  = '0;
				err_d    = wrhp_pkg::ST_OK;
			end
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			phase_q  <= PH_HEADER;
			tag_q    <= '0;
			clen_q   <= '0;
			left_q   <= '0;
			in_fmt_q <= 1'b0;
			for (int i = 0; i < NFMT; i++) fmt_q[i] <= '0;
			doff_q   <= '0;
			dsize_q  <= '0;
			found_q  <= '0;
			err_q    <= wrhp_pkg::ST_OK;
		end else begin
			pos_q    <= pos_d;
			phase_q  <= phase_d;
			tag_q    <= tag_d;
			clen_q   <= clen_d;
			left_q   <= left_d;
			in_fmt_q <= in_fmt_d;
			fmt_q    <= fmt_d;
			doff_q   <= doff_d;
			dsize_q  <= dsize_d;
			found_q  <= found_d;
			err_q    <= err_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv && eof_s1) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && eof_s1) begin
			out_item_q <= res_d;
		end
	end

`ifndef SYNTHESIS
	// a latched error always parks the parser
	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != wrhp_pkg::ST_OK) |-> (phase_q == PH_DONE))
		else $error("error latched outside done phase");

	// fmt capture only while inside a chunk body
	a_fmt_body: assert property (@(posedge clk) disable iff (!arst_n)
		in_fmt_q |-> (phase_q == PH_BODY))
		else $error("fmt capture outside a body");

	// header byte count stays within eight
	a_hdr_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CHUNK_HDR) |-> (left_q < 33'd8))
		else $error("chunk header count out of range");

	// final byte resets the parse state
	a_eof_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && eof_s1) |=> (pos_q == '0 && phase_q == PH_HEADER && found_q == 2'b00))
		else $error("state not cleared after end of file");

	// a new report appears only after a final byte was taken
	a_rep_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(adv && eof_s1))
		else $error("report without end of file");
`endif

endmodule

>>> verif/tb_wav_riff_header_parser_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wav_riff_header_parser_unit
// Streams WAV files byte by byte into the parser and checks every status
// report. A local parse model predicts each report; directed files cover
// the header checks and the status codes, then random files follow.
// ----------------------------------------------------------------------------
module tb_wav_riff_header_parser_unit;

	localparam int          CYCLE_LIMIT = 500000;
	localparam logic [31:0] POS_SAT     =
		32'((64'd1 << wrhp_pkg::OFFSET_BITS_DEF) - 64'd1);
	localparam logic [31:0] TAG_LIST    = 32'h4C49_5354;

	// parse phases of the local model
	typedef enum logic [2:0] {
		SCAN_RIFF, CHUNK_HEAD, CHUNK_BODY, SHORT_FMT, HALTED
	} walk_t;

	logic clk;
	logic arst_n;

	wrhp_in_if  in_ch ();
	wrhp_out_if out_ch ();

	wav_riff_header_parser_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (in_ch),
		.result (out_ch)
	);

	// model state
	logic [31:0] pos_cnt;
	walk_t       walk;
	logic [31:0] tag_sr;
	logic [31:0] clen;
	logic [32:0] remain;
	logic        fmt_live;
	logic [7:0]  fmt_buf [wrhp_pkg::FMT_BYTES];
	logic [31:0] data_off;
	logic [31:0] data_len;
	logic [1:0]  seen;      // bit 0 fmt, bit 1 data
	logic [2:0]  err_code;

	wrhp_pkg::out_item_t pending_reports [$];
	logic [7:0]          wav_bytes [$];

	int  fault_cnt  = 0;
	int  bytes_sent = 0;
	int  cycle_cnt  = 0;
	bit  src_gaps   = 1'b1;
	bit  sink_stalls = 1'b1;

	// ------------------------------------------------------------------
	// parse model
	// ------------------------------------------------------------------
	function automatic void clear_parse();
		pos_cnt  = '0;
		walk     = SCAN_RIFF;
		tag_sr   = '0;
		clen     = '0;
		remain   = '0;
		fmt_live = 1'b0;
		foreach (fmt_buf[i]) fmt_buf[i] = '0;
		data_off = '0;
		data_len = '0;
		seen     = '0;
		err_code = wrhp_pkg::ST_OK;
	endfunction

	function automatic void halt(input logic [2:0] code);
		err_code = code;
		walk     = HALTED;
	endfunction

	// a short fmt body latches its error only once body and pad are in
	function automatic void close_body();
		if (walk == SHORT_FMT) begin
			halt(wrhp_pkg::ST_FMT_SMALL);
		end else begin
			walk     = CHUNK_HEAD;
			remain   = '0;
			fmt_live = 1'b0;
		end
	endfunction

	function automatic logic [15:0] fmt_le16(input int i);
		return {fmt_buf[i + 1], fmt_buf[i]};
	endfunction

	function automatic void parse_byte(input logic [31:0] pos, input logic [7:0] b);
		logic [2:0]  k;
		logic [32:0] idx;
		case (walk)
		SCAN_RIFF: begin
			tag_sr = {tag_sr[23:0], b};
			if (pos == 32'd3 && tag_sr != wrhp_pkg::TAG_RIFF) begin
				halt(wrhp_pkg::ST_BAD_HDR);
			end else if (pos >= 32'd11) begin
				if (tag_sr != wrhp_pkg::TAG_WAVE) begin
					halt(wrhp_pkg::ST_BAD_HDR);
				end else begin
					walk   = CHUNK_HEAD;
					remain = '0;
				end
			end
		end
		CHUNK_HEAD: begin
			k = remain[2:0];
			if (k < 3'd4)
				tag_sr = {tag_sr[23:0], b};
			else if (k == 3'd4)
				clen = {24'd0, b};
			else
				clen[8 * (int'(k) - 4) +: 8] = b;
			remain = 33'(k) + 33'd1;
			// size complete: enter the body
			if (k == 3'd7) begin
				remain   = {1'b0, clen} + clen[0];
				fmt_live = 1'b0;
				walk     = CHUNK_BODY;
				if (tag_sr == wrhp_pkg::TAG_FMT) begin
					if (clen < wrhp_pkg::MIN_FMT) begin
						walk = SHORT_FMT;
					end else begin
						fmt_live = 1'b1;
						foreach (fmt_buf[i]) fmt_buf[i] = '0;
						seen[0] = 1'b1;
					end
				end else if (tag_sr == wrhp_pkg::TAG_DATA) begin
					data_off = pos_cnt;
					data_len = clen;
					seen[1]  = 1'b1;
				end
				if (remain == '0)
					close_body();
			end
		end
		CHUNK_BODY, SHORT_FMT: begin
			if (remain == '0) begin
				close_body();
			end else begin
				idx = ({1'b0, clen} + clen[0]) - remain;
				if (fmt_live && idx < wrhp_pkg::FMT_BYTES &&
				    (idx < wrhp_pkg::MIN_FMT || clen > wrhp_pkg::MIN_FMT))
					fmt_buf[idx[4:0]] = b;
				remain = remain - 33'd1;
				if (remain == '0)
					close_body();
			end
		end
		default: ;
		endcase
	endfunction

	// one accepted byte; the final byte of a file queues its report
	function automatic void track_byte(input logic [7:0] b, input logic last);
		logic [31:0]         pos;
		logic [2:0]          st;
		wrhp_pkg::out_item_t rep;
		pos = pos_cnt;
		if (pos_cnt < POS_SAT)
			pos_cnt = pos_cnt + 32'd1;
		if (err_code == wrhp_pkg::ST_OK)
			parse_byte(pos, b);
		if (last) begin
			if (pos_cnt < wrhp_pkg::MIN_FILE || err_code == wrhp_pkg::ST_BAD_HDR)
				st = wrhp_pkg::ST_BAD_HDR;
			else if (err_code != wrhp_pkg::ST_OK)
				st = err_code;
			else if ((walk == CHUNK_BODY || walk == SHORT_FMT) && remain != '0)
				st = wrhp_pkg::ST_OVERRUN;
			else if (seen != 2'b11)
				st = wrhp_pkg::ST_MISSING;
			else if (fmt_le16(0) != 16'd1)
				st = wrhp_pkg::ST_NOT_PCM;
			else if (fmt_le16(14) != 16'd8)
				st = wrhp_pkg::ST_NOT_8BIT;
			else
				st = wrhp_pkg::ST_OK;
			rep = '0;
			rep.status = st;
			if (st == wrhp_pkg::ST_OK || st == wrhp_pkg::ST_NOT_PCM ||
			    st == wrhp_pkg::ST_NOT_8BIT) begin
				rep.format_tag    = fmt_le16(0);
				rep.channel_count = fmt_le16(2);
				rep.sample_rate   = {fmt_le16(6), fmt_le16(4)};
				rep.byte_rate     = {fmt_le16(10), fmt_le16(8)};
				rep.block_align   = fmt_le16(12);
				rep.sample_bits   = fmt_le16(14);
				rep.extra_size    = fmt_le16(16);
				rep.data_offset   = data_off;
				rep.data_size     = data_len;
			end
			pending_reports.push_back(rep);
			clear_parse();
		end
	endfunction

	// ------------------------------------------------------------------
	// file builder
	// ------------------------------------------------------------------
	function automatic void put_tag(input logic [31:0] tag);
		int i;
		for (i = 3; i >= 0; i--)
			wav_bytes.push_back(tag[8 * i +: 8]);
	endfunction

	function automatic void put_le32(input logic [31:0] v);
		int i;
		for (i = 0; i < 4; i++)
			wav_bytes.push_back(v[8 * i +: 8]);
	endfunction

	function automatic void put_noise(input int n);
		int i;
		for (i = 0; i < n; i++)
			wav_bytes.push_back(8'($urandom));
	endfunction

	// RIFF header; the masks flip bits of either tag
	function automatic void put_head(input logic [31:0] riff_x, input logic [31:0] wave_x);
		put_tag(wrhp_pkg::TAG_RIFF ^ riff_x);
		put_le32($urandom);
		put_tag(wrhp_pkg::TAG_WAVE ^ wave_x);
	endfunction

	// fmt chunk; fill < 0 gives random fields beside tag and sample size
	function automatic void put_fmt(input logic [31:0] size, input logic [15:0] ftag,
			input logic [15:0] bits, input int fill);
		logic [7:0]  body [16];
		logic [32:0] total;
		int          i;
		put_tag(wrhp_pkg::TAG_FMT);
		put_le32(size);
		foreach (body[j]) body[j] = (fill < 0) ? 8'($urandom) : 8'(fill);
		{body[1], body[0]}   = ftag;
		{body[15], body[14]} = bits;
		total = {1'b0, size} + size[0];
		for (i = 0; i < total; i++)
			wav_bytes.push_back((i < 16 && i < size) ? body[i] : 8'($urandom));
	endfunction

	// generic chunk, body capped so huge sizes end the file inside it
	function automatic void put_chunk(input logic [31:0] tag, input logic [31:0] size);
		logic [32:0] total;
		put_tag(tag);
		put_le32(size);
		total = {1'b0, size} + size[0];
		if (total > 33'd80)
			total = 33'd80;
		put_noise(int'(total));
	endfunction

	// kind: 0 fmt, 1 data, else some other chunk
	function automatic void put_rand_chunk(input int kind);
		int          r;
		logic [31:0] sz;
		r = $urandom_range(0, 19);
		case (kind)
		0: begin
			if (r < 12)
				sz = 16;
			else if (r < 14)
				sz = 17;
			else if (r < 16)
				sz = 18;
			else if (r < 18)
				sz = $urandom_range(19, 40);
			else
				sz = $urandom_range(0, 15);
			put_fmt(sz, ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'd1,
				($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'd8, -1);
		end
		1: put_chunk(wrhp_pkg::TAG_DATA, (r == 0) ? $urandom : $urandom_range(0, 48));
		default: put_chunk($urandom, $urandom_range(0, 24));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// driving
	// ------------------------------------------------------------------
	task automatic push_byte(input logic [7:0] b, input logic last);
		if (src_gaps && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.item  <= '{file_byte: b, end_of_file: last};
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		track_byte(b, last);
		bytes_sent++;
	endtask

	// send the built file, cut to keep bytes when 0 < keep < size
	task automatic send_file(input int keep);
		int n;
		int i;
		n = wav_bytes.size();
		if (keep > 0 && keep < n)
			n = keep;
		for (i = 0; i < n; i++)
			push_byte(wav_bytes[i], i == n - 1);
		wav_bytes.delete();
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_minimal_pcm();
		put_head('0, '0);
		put_fmt(16, 16'd1, 16'd8, 0);
		put_chunk(wrhp_pkg::TAG_DATA, 0);
		send_file(0);
		// all-ones fields, odd data size with pad
		put_head('0, '0);
		put_fmt(16, 16'd1, 16'd8, 255);
		put_chunk(wrhp_pkg::TAG_DATA, 3);
		send_file(0);
	endtask

	task automatic test_bad_tags();
		put_head(32'h0000_0001, '0);
		put_fmt(16, 16'd1, 16'd8, -1);
		put_chunk(wrhp_pkg::TAG_DATA, 8);
		send_file(0);
		put_head('0, 32'h8000_0000);
		put_fmt(16, 16'd1, 16'd8, -1);
		put_chunk(wrhp_pkg::TAG_DATA, 8);
		send_file(0);
		// all-zero and all-ones files
		repeat (50) wav_bytes.push_back(8'h00);
		send_file(0);
		repeat (50) wav_bytes.push_back(8'hFF);
		send_file(0);
	endtask

	task automatic test_short_files();
		// one-byte files back to back: the second end of file waits on the report
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h52, 1'b1);
		put_head('0, '0);
		put_fmt(16, 16'd1, 16'd8, -1);
		put_chunk(wrhp_pkg::TAG_DATA, 8);
		send_file(wrhp_pkg::MIN_FILE - 1);
		// empty fmt latches its error, but a short file still reads as bad header
		put_head('0, '0);
		put_fmt(0, 16'd1, 16'd8, -1);
		send_file(0);
	endtask

	task automatic test_small_fmt();
		put_head('0, '0);
		put_fmt(14, 16'd1, 16'd8, -1);
		put_chunk(wrhp_pkg::TAG_DATA, 16);
		send_file(0);
		put_head('0, '0);
		put_fmt(15, 16'd1, 16'd8, -1);
		put_chunk(wrhp_pkg::TAG_DATA, 16);
		send_file(0);
		put_head('0, '0);
		put_fmt(0, 16'd1, 16'd8, -1);
		put_chunk(wrhp_pkg::TAG_DATA, 30);
		send_file(0);
		// file ends inside the short fmt body: overrun wins
		put_head('0, '0);
		put_chunk(TAG_LIST, 20);
		put_fmt(15, 16'd1, 16'd8, -1);
		send_file(58);
	endtask

	task automatic test_overrun();
		put_head('0, '0);
		put_fmt(16, 16'd1, 16'd8, -1);
		put_chunk(wrhp_pkg::TAG_DATA, 40);
		send_file(wav_bytes.size() - 3);
		// stop just before the pad byte
		put_head('0, '0);
		put_fmt(16, 16'd1, 16'd8, -1);
		put_chunk(wrhp_pkg::TAG_DATA, 5);
		send_file(wav_bytes.size() - 1);
		// largest size: the body count must not wrap
		put_head('0, '0);
		put_fmt(16, 16'd1, 16'd8, -1);
		put_chunk(wrhp_pkg::TAG_DATA, 32'hFFFF_FFFF);
		send_file(0);
	endtask

	task automatic test_missing_chunks();
		put_head('0, '0);
		put_fmt(16, 16'd1, 16'd8, -1);
		put_chunk(TAG_LIST, 20);
		send_file(0);
		put_head('0, '0);
		put_chunk(wrhp_pkg::TAG_DATA, 30);
		send_file(0);
	endtask

	task automatic test_format_checks();
		put_head('0, '0);
		put_fmt(16, 16'd3, 16'd8, -1);
		put_chunk(wrhp_pkg::TAG_DATA, 4);
		send_file(0);
		put_head('0, '0);
		put_fmt(16, 16'hFFFF, 16'd8, 255);
		put_chunk(wrhp_pkg::TAG_DATA, 4);
		send_file(0);
		put_head('0, '0);
		put_fmt(16, 16'd1, 16'd16, -1);
		put_chunk(wrhp_pkg::TAG_DATA, 4);
		send_file(0);
		put_head('0, '0);
		put_fmt(16, 16'd1, 16'd0, 0);
		put_chunk(wrhp_pkg::TAG_DATA, 4);
		send_file(0);
	endtask

	task automatic test_fmt_extension();
		// size 17: the pad byte lands in the top of the extension size
		put_head('0, '0);
		put_fmt(17, 16'd1, 16'd8, -1);
		put_chunk(wrhp_pkg::TAG_DATA, 6);
		send_file(0);
		put_head('0, '0);
		put_fmt(18, 16'd1, 16'd8, -1);
		put_chunk(wrhp_pkg::TAG_DATA, 6);
		send_file(0);
		put_head('0, '0);
		put_fmt(40, 16'd1, 16'd8, -1);
		put_chunk(wrhp_pkg::TAG_DATA, 6);
		send_file(0);
	endtask

	task automatic test_chunk_walk();
		// last fmt and last data win; odd chunk padded; short tail ignored
		put_head('0, '0);
		put_fmt(16, 16'd3, 16'd16, -1);
		put_chunk(TAG_LIST, 7);
		put_chunk(wrhp_pkg::TAG_DATA, 4);
		put_fmt(18, 16'd1, 16'd8, -1);
		put_chunk(wrhp_pkg::TAG_DATA, 9);
		put_noise(5);
		send_file(0);
		put_head('0, '0);
		put_chunk(wrhp_pkg::TAG_DATA, 10);
		put_fmt(16, 16'd1, 16'd8, -1);
		put_noise(7);
		send_file(0);
	endtask

	// random files, mostly well formed; quiet turns all idling off
	task automatic test_random_files(input int min_bytes, input int min_files, input bit quiet);
		int          start;
		int          files;
		int          kind;
		int          keep;
		int          i;
		logic [31:0] flip;
		start = bytes_sent;
		files = 0;
		while (bytes_sent - start < min_bytes || files < min_files) begin
			src_gaps    = !quiet && ($urandom_range(0, 3) != 0);
			sink_stalls = !quiet && ($urandom_range(0, 3) != 0);
			kind = $urandom_range(0, 15);
			keep = 0;
			flip = 32'd1 << $urandom_range(0, 31);
			if (kind == 0) begin
				put_noise($urandom_range(1, 60));
			end else begin
				put_head((kind == 1) ? flip : '0, (kind == 2) ? flip : '0);
				if ($urandom_range(0, 9) < 7) begin
					put_rand_chunk(0);
					repeat ($urandom_range(0, 2)) put_rand_chunk($urandom_range(0, 2));
					put_rand_chunk(1);
				end else begin
					for (i = $urandom_range(1, 4); i > 0; i--)
						put_rand_chunk($urandom_range(0, 2));
				end
				if ($urandom_range(0, 3) == 0)
					put_noise($urandom_range(1, 7));
				if ($urandom_range(0, 7) == 0)
					keep = $urandom_range(1, wav_bytes.size());
			end
			send_file(keep);
			files++;
		end
	endtask

	// ------------------------------------------------------------------
	// report checking
	// ------------------------------------------------------------------
	function automatic string diff_fields(input wrhp_pkg::out_item_t want,
			input wrhp_pkg::out_item_t got);
		string s;
		s = "";
		if (want.status        !== got.status)        s = {s, " status"};
		if (want.format_tag    !== got.format_tag)    s = {s, " format_tag"};
		if (want.channel_count !== got.channel_count) s = {s, " channel_count"};
		if (want.sample_rate   !== got.sample_rate)   s = {s, " sample_rate"};
		if (want.byte_rate     !== got.byte_rate)     s = {s, " byte_rate"};
		if (want.block_align   !== got.block_align)   s = {s, " block_align"};
		if (want.sample_bits   !== got.sample_bits)   s = {s, " sample_bits"};
		if (want.extra_size    !== got.extra_size)    s = {s, " extra_size"};
		if (want.data_offset   !== got.data_offset)   s = {s, " data_offset"};
		if (want.data_size     !== got.data_size)     s = {s, " data_size"};
		return s;
	endfunction

	function automatic void note_fault(input string what, input wrhp_pkg::out_item_t want,
			input wrhp_pkg::out_item_t got);
		fault_cnt++;
		if (fault_cnt <= 10)
			$display("%0t: %s\n  exp %h\n  got %h", $time, what, want, got);
	endfunction

	always @(posedge clk) begin
		wrhp_pkg::out_item_t want;
		string               diffs;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_reports.size() == 0) begin
				note_fault("report with none pending", '0, out_ch.item);
			end else begin
				want  = pending_reports.pop_front();
				diffs = diff_fields(want, out_ch.item);
				if (diffs != "")
					note_fault({"report mismatch:", diffs}, want, out_ch.item);
			end
		end
	end

	// ------------------------------------------------------------------
	// clock, sink stalls, watchdog
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		out_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (sink_stalls && $urandom_range(0, 7) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n      <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.item  <= '0;
		clear_parse();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_minimal_pcm();
		test_bad_tags();
		test_short_files();
		test_small_fmt();
		test_overrun();
		test_missing_chunks();
		test_format_checks();
		test_fmt_extension();
		test_chunk_walk();
		test_random_files(400, 6, 1'b0);
		test_random_files(120, 2, 1'b1);

		in_ch.valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (pending_reports.size() != 0)
			fault_cnt++;
		if (fault_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
